>>> rtl/uat_pkg.sv
// ----------------------------------------------------------------------------
// uat_pkg
// Shared codes and types of the update attempt tracker.
// ----------------------------------------------------------------------------
package uat_pkg;

  // event opcodes
  localparam logic [2:0] OP_BOOT_CHECK    = 3'd0;
  localparam logic [2:0] OP_RECEIVING     = 3'd1;
  localparam logic [2:0] OP_PROGRESS      = 3'd2;
  localparam logic [2:0] OP_VERIFYING     = 3'd3;
  localparam logic [2:0] OP_VERIFIED      = 3'd4;
  localparam logic [2:0] OP_FINALIZE_FAIL = 3'd5;
  localparam logic [2:0] OP_BOOTSEL_FAIL  = 3'd6;
  localparam logic [2:0] OP_BOOT_SELECTED = 3'd7;

  // attempt outcomes
  localparam logic [3:0] OUT_NONE          = 4'd0;
  localparam logic [3:0] OUT_PENDING       = 4'd1;
  localparam logic [3:0] OUT_APPLIED       = 4'd2;
  localparam logic [3:0] OUT_ROLLED_BACK   = 4'd3;
  localparam logic [3:0] OUT_UNEXPECTED    = 4'd4;
  localparam logic [3:0] OUT_INT_FINALIZE  = 4'd5;
  localparam logic [3:0] OUT_FINALIZE_FAIL = 4'd6;
  localparam logic [3:0] OUT_BOOTSEL_FAIL  = 4'd7;
  localparam logic [3:0] OUT_INT_UPLOAD    = 4'd8;

  // phases
  localparam logic [2:0] PH_NONE          = 3'd0;
  localparam logic [2:0] PH_RECEIVING     = 3'd1;
  localparam logic [2:0] PH_VERIFYING     = 3'd2;
  localparam logic [2:0] PH_VERIFIED      = 3'd3;
  localparam logic [2:0] PH_BOOT_SELECTED = 3'd4;

  localparam logic [7:0] CAUSE_UNKNOWN = 8'hFF;

  // register map
  localparam int unsigned PADDR_W = 3;
  localparam logic [0:0]  REG_STORAGE_READY = 1'b0;

  typedef struct packed {
    logic [2:0]         opcode;
    logic               slots_present;
    logic [31:0]        source_addr;
    logic [31:0]        target_addr;
    logic [31:0]        image_size;
    logic [31:0]        received_size;
    logic signed [31:0] error_value;
    logic               running_present;
    logic [31:0]        running_addr;
    logic [7:0]         reset_cause;
  } uat_event_t;

  typedef struct packed {
    logic [3:0]         outcome;
    logic [2:0]         phase;
    logic [31:0]        attempt;
    logic [31:0]        source;
    logic [31:0]        target;
    logic [31:0]        size;
    logic [31:0]        received;
    logic signed [31:0] error;
    logic [7:0]         reset_cause;
    logic               healthy;
  } uat_state_t;

  typedef struct packed {
    logic               accepted;
    logic [3:0]         outcome;
    logic [2:0]         phase_now;
    logic [31:0]        attempt_count;
    logic [7:0]         last_reset;
    logic signed [31:0] error_code;
    logic [31:0]        progress_bytes;
    logic               healthy;
  } uat_result_t;

endpackage

>>> rtl/uat_evt_if.sv
// ----------------------------------------------------------------------------
// uat_evt_if
// Event channel: valid/ready handshake with the event fields.
// ----------------------------------------------------------------------------
interface uat_evt_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic               slots_present;
  logic [31:0]        source_addr;
  logic [31:0]        target_addr;
  logic [31:0]        image_size;
  logic [31:0]        received_size;
  logic signed [31:0] error_value;
  logic               running_present;
  logic [31:0]        running_addr;
  logic [7:0]         reset_cause;

  modport source (
    output valid, opcode, slots_present, source_addr, target_addr, image_size,
           received_size, error_value, running_present, running_addr, reset_cause,
    input  ready
  );
  modport sink (
    input  valid, opcode, slots_present, source_addr, target_addr, image_size,
           received_size, error_value, running_present, running_addr, reset_cause,
    output ready
  );
endinterface

>>> rtl/uat_res_if.sv
// ----------------------------------------------------------------------------
// uat_res_if
// Result channel: valid/ready handshake with the tracker status fields.
// ----------------------------------------------------------------------------
interface uat_res_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [3:0]         outcome;
  logic [2:0]         phase_now;
  logic [31:0]        attempt_count;
  logic [7:0]         last_reset;
  logic signed [31:0] error_code;
  logic [31:0]        progress_bytes;
  logic               healthy;

  modport source (
    output valid, accepted, outcome, phase_now, attempt_count, last_reset,
           error_code, progress_bytes, healthy,
    input  ready
  );
  modport sink (
    input  valid, accepted, outcome, phase_now, attempt_count, last_reset,
           error_code, progress_bytes, healthy,
    output ready
  );
endinterface

>>> rtl/uat_cfg_regs.sv
// ----------------------------------------------------------------------------
// uat_cfg_regs
// APB register file holding the storage-ready flag.
// ----------------------------------------------------------------------------
module uat_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [uat_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic                       storage_ready_o
);
  import uat_pkg::*;

  logic storage_ready_q;
  logic wr_en;
  logic sel_ready;

  assign pready    = 1'b1;
  assign sel_ready = (paddr[PADDR_W-1:2] == REG_STORAGE_READY);
  assign wr_en     = psel && penable && pwrite && pready && sel_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      storage_ready_q <= 1'b1;
    end else if (wr_en) begin
      storage_ready_q <= pwdata[0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (sel_ready) begin
      prdata = {31'd0, storage_ready_q};
    end
  end

  assign storage_ready_o = storage_ready_q;
endmodule

>>> rtl/uat_event_logic.sv
// ----------------------------------------------------------------------------
// uat_event_logic
// Precondition checks and next tracker state for one event.
// ----------------------------------------------------------------------------
module uat_event_logic (
  input  logic                storage_ready_i,
  input  uat_pkg::uat_event_t evt_i,
  input  uat_pkg::uat_state_t st_i,
  output uat_pkg::uat_state_t st_o,
  output logic                accepted_o
);
  import uat_pkg::*;

  logic        pending;
  logic        start_ok;
  logic        same_attempt;
  logic [31:0] attempt_inc;
  logic        ok;

  assign pending      = (st_i.outcome == OUT_PENDING);
  assign start_ok     = evt_i.slots_present && (evt_i.image_size != 32'd0);
  assign same_attempt = (st_i.source == evt_i.source_addr) &&
                        (st_i.target == evt_i.target_addr) &&
                        (st_i.size == evt_i.image_size);
  // counter skips zero on wrap
  assign attempt_inc  = (st_i.attempt == 32'hFFFF_FFFF) ? 32'd1 : st_i.attempt + 32'd1;

  always_comb begin
    st_o = st_i;
    ok   = 1'b0;
    if (storage_ready_i) begin
      case (evt_i.opcode)
        OP_BOOT_CHECK: begin
          ok = 1'b1;
          if (pending && evt_i.running_present) begin
            st_o.reset_cause = evt_i.reset_cause;
            if (evt_i.running_addr == st_i.target) begin
              st_o.outcome = OUT_APPLIED;
            end else if (evt_i.running_addr == st_i.source) begin
              if (st_i.phase == PH_BOOT_SELECTED) begin
                st_o.outcome = OUT_ROLLED_BACK;
              end else if (st_i.phase == PH_RECEIVING) begin
                st_o.outcome = OUT_INT_UPLOAD;
              end else begin
                st_o.outcome = OUT_INT_FINALIZE;
              end
            end else begin
              st_o.outcome = OUT_UNEXPECTED;
            end
          end
        end
        OP_RECEIVING: begin
          if (start_ok) begin
            ok                = 1'b1;
            st_o.attempt      = attempt_inc;
            st_o.outcome      = OUT_PENDING;
            st_o.phase        = PH_RECEIVING;
            st_o.source       = evt_i.source_addr;
            st_o.target       = evt_i.target_addr;
            st_o.size         = evt_i.image_size;
            st_o.error        = 32'sd0;
            st_o.reset_cause  = CAUSE_UNKNOWN;
            st_o.received     = 32'd0;
          end
        end
        OP_PROGRESS: begin
          if (pending && (st_i.phase == PH_RECEIVING) && (evt_i.received_size <= st_i.size)) begin
            ok            = 1'b1;
            st_o.received = evt_i.received_size;
          end
        end
        OP_VERIFYING: begin
          if (start_ok) begin
            ok = 1'b1;
            if (!(pending && (st_i.phase == PH_RECEIVING) && same_attempt)) begin
              st_o.attempt = attempt_inc;
            end
            st_o.outcome     = OUT_PENDING;
            st_o.phase       = PH_VERIFYING;
            st_o.source      = evt_i.source_addr;
            st_o.target      = evt_i.target_addr;
            st_o.size        = evt_i.image_size;
            st_o.error       = 32'sd0;
            st_o.reset_cause = CAUSE_UNKNOWN;
            st_o.received    = evt_i.image_size;
          end
        end
        OP_VERIFIED: begin
          if (pending && (st_i.phase == PH_VERIFYING)) begin
            ok         = 1'b1;
            st_o.phase = PH_VERIFIED;
          end
        end
        OP_FINALIZE_FAIL: begin
          if (pending && (st_i.phase == PH_VERIFYING)) begin
            ok           = 1'b1;
            st_o.outcome = OUT_FINALIZE_FAIL;
            st_o.error   = evt_i.error_value;
          end
        end
        OP_BOOTSEL_FAIL: begin
          if (pending && (st_i.phase == PH_VERIFIED)) begin
            ok           = 1'b1;
            st_o.outcome = OUT_BOOTSEL_FAIL;
            st_o.error   = evt_i.error_value;
          end
        end
        OP_BOOT_SELECTED: begin
          if (start_ok) begin
            ok = 1'b1;
            if (!(pending && ((st_i.phase == PH_VERIFYING) || (st_i.phase == PH_VERIFIED)) &&
                  same_attempt)) begin
              st_o.attempt = attempt_inc;
            end
            // reset cause is kept here
            st_o.outcome  = OUT_PENDING;
            st_o.phase    = PH_BOOT_SELECTED;
            st_o.source   = evt_i.source_addr;
            st_o.target   = evt_i.target_addr;
            st_o.size     = evt_i.image_size;
            st_o.error    = 32'sd0;
            st_o.received = evt_i.image_size;
          end
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end
    st_o.healthy = ok;
  end

  assign accepted_o = ok;
endmodule

>>> rtl/update_attempt_tracker.sv
// ----------------------------------------------------------------------------
// update_attempt_tracker
// Follows a firmware-update attempt through its phases, one event per item.
//
//   channel  | dir | handshake           | payload
//   evt_i    | in  | valid/ready         | opcode, slots, addresses, sizes, error
//   res_o    | out | valid/ready         | accepted, outcome, phase, counters
//   apb      | in  | psel/penable/pready | storage_ready at byte address 0
//
// An event is registered on acceptance and evaluated against the tracker
// state once the result slot is free or draining; state and result register
// update together. The result is registered after the event register; one
// event per cycle is sustained while the receiver takes results. The input
// stage keeps accepting while a result waits, until both stages hold an item.
// Reset clears the state to no attempt, reset cause unknown, healthy set.
// ----------------------------------------------------------------------------
module update_attempt_tracker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  uat_evt_if.sink                     evt_i,
  uat_res_if.source                   res_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [uat_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import uat_pkg::*;

  logic        storage_ready;
  uat_event_t  evt_d, evt_q;
  logic        evt_vld_q;
  uat_state_t  st_q, st_d;
  uat_result_t res_d, res_q;
  logic        res_vld_q;
  logic        accepted;
  logic        adv;
  logic        take;

  uat_cfg_regs u_cfg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .storage_ready_o (storage_ready)
  );

  uat_event_logic u_logic (
    .storage_ready_i (storage_ready),
    .evt_i           (evt_q),
    .st_i            (st_q),
    .st_o            (st_d),
    .accepted_o      (accepted)
  );

  // evaluate when the result slot is free or being drained
  assign adv         = evt_vld_q && (!res_vld_q || res_o.ready);
  assign evt_i.ready = !evt_vld_q || adv;
  assign take        = evt_i.valid && evt_i.ready;

  always_comb begin
    evt_d.opcode          = evt_i.opcode;
    evt_d.slots_present   = evt_i.slots_present;
    evt_d.source_addr     = evt_i.source_addr;
    evt_d.target_addr     = evt_i.target_addr;
    evt_d.image_size      = evt_i.image_size;
    evt_d.received_size   = evt_i.received_size;
    evt_d.error_value     = evt_i.error_value;
    evt_d.running_present = evt_i.running_present;
    evt_d.running_addr    = evt_i.running_addr;
    evt_d.reset_cause     = evt_i.reset_cause;

    res_d.accepted       = accepted;
    res_d.outcome        = st_d.outcome;
    res_d.phase_now      = st_d.phase;
    res_d.attempt_count  = st_d.attempt;
    res_d.last_reset     = st_d.reset_cause;
    res_d.error_code     = st_d.error;
    res_d.progress_bytes = st_d.received;
    res_d.healthy        = st_d.healthy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_vld_q <= 1'b0;
    end else if (evt_i.ready) begin
      evt_vld_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      evt_q <= evt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.outcome     <= OUT_NONE;
      st_q.phase       <= PH_NONE;
      st_q.attempt     <= 32'd0;
      st_q.source      <= 32'd0;
      st_q.target      <= 32'd0;
      st_q.size        <= 32'd0;
      st_q.received    <= 32'd0;
      st_q.error       <= 32'sd0;
      st_q.reset_cause <= CAUSE_UNKNOWN;
      st_q.healthy     <= 1'b1;
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (adv) begin
      res_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid          = res_vld_q;
  assign res_o.accepted       = res_q.accepted;
  assign res_o.outcome        = res_q.outcome;
  assign res_o.phase_now      = res_q.phase_now;
  assign res_o.attempt_count  = res_q.attempt_count;
  assign res_o.last_reset     = res_q.last_reset;
  assign res_o.error_code     = res_q.error_code;
  assign res_o.progress_bytes = res_q.progress_bytes;
  assign res_o.healthy        = res_q.healthy;

  // healthy always mirrors the acceptance of the latest event
  a_healthy_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> (res_q.healthy == res_q.accepted))
    else $error("healthy differs from accepted");

  // a rejected event leaves the attempt record untouched
  a_reject_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !accepted) |=> ((st_q.outcome == $past(st_q.outcome)) &&
                            (st_q.phase == $past(st_q.phase)) &&
                            (st_q.attempt == $past(st_q.attempt))))
    else $error("rejected event changed state");

  // with the store closed nothing is accepted
  a_store_closed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !storage_ready) |=> (res_vld_q && !res_q.accepted))
    else $error("event accepted while store closed");

  // once an attempt has started the counter never returns to zero
  a_attempt_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.attempt != 32'd0) |=> (st_q.attempt != 32'd0))
    else $error("attempt counter returned to zero");
endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the update attempt tracker. A short table of
// directed events comes first, then random update flows and noise, under
// several idle and stall patterns and with the store closed and open. Every
// result item is checked field by field against a tracker model or a fixed row.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import uat_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT  = 8;
  localparam int unsigned REG_SPARE   = 1;
  localparam logic [PADDR_W-1:0] ADDR_STORAGE = PADDR_W'(4 * REG_STORAGE_READY);
  localparam logic [PADDR_W-1:0] ADDR_SPARE   = PADDR_W'(4 * REG_SPARE);

  typedef struct {
    uat_event_t  ev;
    bit          fixed_on;
    uat_result_t fixed;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  uat_evt_if evt ();
  uat_res_if res ();

  update_attempt_tracker dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .evt_i   (evt),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk_i = ~clk_i;

  // tracker model state
  uat_state_t  trk;
  bit          store_open;
  uat_result_t status_due[$];

  // typed expectation travelling with the item on the bus
  bit          row_fixed_on;
  uat_result_t row_fixed;

  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;
  int unsigned hold_len     = 0;

  // random flow generator
  logic [31:0] gen_src;
  logic [31:0] gen_tgt;
  logic [31:0] gen_size;
  uat_event_t  script_q[$];
  dir_row_t    dir_rows[$];

  function automatic logic [31:0] next_attempt(input logic [31:0] a);
    return (a + 32'd1 == 32'd0) ? 32'd1 : a + 32'd1;
  endfunction

  function automatic void open_attempt(input logic [2:0] ph, input uat_event_t ev);
    trk.outcome = OUT_PENDING;
    trk.phase   = ph;
    trk.source  = ev.source_addr;
    trk.target  = ev.target_addr;
    trk.size    = ev.image_size;
    trk.error   = '0;
  endfunction

  function automatic uat_result_t track_event(input uat_event_t ev);
    uat_result_t r;
    logic        pend;
    logic        start_ok;
    logic        same;
    logic        ok;
    pend     = (trk.outcome == OUT_PENDING);
    start_ok = ev.slots_present && (ev.image_size != 32'd0);
    same     = (trk.source == ev.source_addr) && (trk.target == ev.target_addr) &&
               (trk.size == ev.image_size);
    ok       = 1'b0;
    if (store_open) begin
      case (ev.opcode)
        OP_BOOT_CHECK: begin
          ok = 1'b1;
          if (pend && ev.running_present) begin
            trk.reset_cause = ev.reset_cause;
            if (ev.running_addr == trk.target) begin
              trk.outcome = OUT_APPLIED;
            end else if (ev.running_addr == trk.source) begin
              if (trk.phase == PH_BOOT_SELECTED) trk.outcome = OUT_ROLLED_BACK;
              else if (trk.phase == PH_RECEIVING) trk.outcome = OUT_INT_UPLOAD;
              else trk.outcome = OUT_INT_FINALIZE;
            end else begin
              trk.outcome = OUT_UNEXPECTED;
            end
          end
        end
        OP_RECEIVING: begin
          if (start_ok) begin
            ok = 1'b1;
            trk.attempt = next_attempt(trk.attempt);
            open_attempt(PH_RECEIVING, ev);
            trk.reset_cause = CAUSE_UNKNOWN;
            trk.received    = '0;
          end
        end
        OP_PROGRESS: begin
          if (pend && trk.phase == PH_RECEIVING && ev.received_size <= trk.size) begin
            ok = 1'b1;
            trk.received = ev.received_size;
          end
        end
        OP_VERIFYING: begin
          if (start_ok) begin
            ok = 1'b1;
            if (!(pend && trk.phase == PH_RECEIVING && same))
              trk.attempt = next_attempt(trk.attempt);
            open_attempt(PH_VERIFYING, ev);
            trk.reset_cause = CAUSE_UNKNOWN;
            trk.received    = ev.image_size;
          end
        end
        OP_VERIFIED: begin
          if (pend && trk.phase == PH_VERIFYING) begin
            ok = 1'b1;
            trk.phase = PH_VERIFIED;
          end
        end
        OP_FINALIZE_FAIL: begin
          if (pend && trk.phase == PH_VERIFYING) begin
            ok = 1'b1;
            trk.outcome = OUT_FINALIZE_FAIL;
            trk.error   = ev.error_value;
          end
        end
        OP_BOOTSEL_FAIL: begin
          if (pend && trk.phase == PH_VERIFIED) begin
            ok = 1'b1;
            trk.outcome = OUT_BOOTSEL_FAIL;
            trk.error   = ev.error_value;
          end
        end
        OP_BOOT_SELECTED: begin
          if (start_ok) begin
            ok = 1'b1;
            if (!(pend && (trk.phase == PH_VERIFYING || trk.phase == PH_VERIFIED) && same))
              trk.attempt = next_attempt(trk.attempt);
            // reset cause is kept here
            open_attempt(PH_BOOT_SELECTED, ev);
            trk.received = ev.image_size;
          end
        end
        default: begin
        end
      endcase
    end
    trk.healthy = ok;
    r.accepted       = ok;
    r.outcome        = trk.outcome;
    r.phase_now      = trk.phase;
    r.attempt_count  = trk.attempt;
    r.last_reset     = trk.reset_cause;
    r.error_code     = trk.error;
    r.progress_bytes = trk.received;
    r.healthy        = trk.healthy;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch on %s at result %0d: got 0x%h, want 0x%h",
               what, results_seen, got, want);
  endtask

  task automatic check_status(input uat_result_t got, input uat_result_t want);
    if (got.accepted !== want.accepted)
      flag_mismatch("accepted", 32'(got.accepted), 32'(want.accepted));
    if (got.outcome !== want.outcome)
      flag_mismatch("outcome", 32'(got.outcome), 32'(want.outcome));
    if (got.phase_now !== want.phase_now)
      flag_mismatch("phase_now", 32'(got.phase_now), 32'(want.phase_now));
    if (got.attempt_count !== want.attempt_count)
      flag_mismatch("attempt_count", got.attempt_count, want.attempt_count);
    if (got.last_reset !== want.last_reset)
      flag_mismatch("last_reset", 32'(got.last_reset), 32'(want.last_reset));
    if (got.error_code !== want.error_code)
      flag_mismatch("error_code", got.error_code, want.error_code);
    if (got.progress_bytes !== want.progress_bytes)
      flag_mismatch("progress_bytes", got.progress_bytes, want.progress_bytes);
    if (got.healthy !== want.healthy)
      flag_mismatch("healthy", 32'(got.healthy), 32'(want.healthy));
  endtask

  // bus monitor: check results, predict each accepted item
  always @(posedge clk_i) begin
    uat_event_t  ev;
    uat_result_t got;
    uat_result_t want;
    if (rst_ni) begin
      if (res.valid && res.ready) begin
        got.accepted       = res.accepted;
        got.outcome        = res.outcome;
        got.phase_now      = res.phase_now;
        got.attempt_count  = res.attempt_count;
        got.last_reset     = res.last_reset;
        got.error_code     = res.error_code;
        got.progress_bytes = res.progress_bytes;
        got.healthy        = res.healthy;
        results_seen++;
        if (status_due.size() == 0) begin
          flag_mismatch("unexpected result", 32'(got.outcome), 32'(OUT_NONE));
        end else begin
          want = status_due.pop_front();
          check_status(got, want);
        end
      end
      if (evt.valid && evt.ready) begin
        ev.opcode          = evt.opcode;
        ev.slots_present   = evt.slots_present;
        ev.source_addr     = evt.source_addr;
        ev.target_addr     = evt.target_addr;
        ev.image_size      = evt.image_size;
        ev.received_size   = evt.received_size;
        ev.error_value     = evt.error_value;
        ev.running_present = evt.running_present;
        ev.running_addr    = evt.running_addr;
        ev.reset_cause     = evt.reset_cause;
        want = track_event(ev);
        if (row_fixed_on) want = row_fixed;
        status_due.push_back(want);
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  initial begin
    res.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_len > 0) begin
        res.ready <= 1'b0;
        hold_len--;
      end else begin
        res.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("simulation failed");
    $finish;
  end

  function automatic uat_event_t mk_event(
      input logic [2:0] op, input logic slots, input logic [31:0] src,
      input logic [31:0] tgt, input logic [31:0] size, input logic [31:0] rcv,
      input logic [31:0] err, input logic run_ok, input logic [31:0] run_addr,
      input logic [7:0] cause);
    uat_event_t ev;
    ev.opcode          = op;
    ev.slots_present   = slots;
    ev.source_addr     = src;
    ev.target_addr     = tgt;
    ev.image_size      = size;
    ev.received_size   = rcv;
    ev.error_value     = err;
    ev.running_present = run_ok;
    ev.running_addr    = run_addr;
    ev.reset_cause     = cause;
    return ev;
  endfunction

  function automatic uat_result_t mk_status(
      input logic acc, input logic [3:0] outc, input logic [2:0] ph,
      input logic [31:0] att, input logic [7:0] last, input logic [31:0] err,
      input logic [31:0] prog, input logic hl);
    uat_result_t r;
    r.accepted       = acc;
    r.outcome        = outc;
    r.phase_now      = ph;
    r.attempt_count  = att;
    r.last_reset     = last;
    r.error_code     = err;
    r.progress_bytes = prog;
    r.healthy        = hl;
    return r;
  endfunction

  function automatic void add_row(input uat_event_t ev, input bit fixed_on,
                                  input uat_result_t fixed);
    dir_row_t row;
    row.ev       = ev;
    row.fixed_on = fixed_on;
    row.fixed    = fixed;
    dir_rows.push_back(row);
  endfunction

  function automatic void load_directed();
    logic [31:0] a;
    logic [31:0] b;
    a = 32'h0801_0000;
    b = 32'h0810_0000;
    // fresh tracker: boot check with nothing pending
    add_row(mk_event(OP_BOOT_CHECK, 1'b1, 0, 0, 0, 0, 0, 1'b1, 32'h5, 8'h3), 1'b1,
            mk_status(1'b1, OUT_NONE, PH_NONE, 0, CAUSE_UNKNOWN, 0, 0, 1'b1));
    // start without slots, then with zero size
    add_row(mk_event(OP_RECEIVING, 1'b0, a, b, 5, 0, 0, 1'b0, 0, 8'h0), 1'b1,
            mk_status(1'b0, OUT_NONE, PH_NONE, 0, CAUSE_UNKNOWN, 0, 0, 1'b0));
    add_row(mk_event(OP_RECEIVING, 1'b1, a, b, 0, 0, 0, 1'b0, 0, 8'h0), 1'b1,
            mk_status(1'b0, OUT_NONE, PH_NONE, 0, CAUSE_UNKNOWN, 0, 0, 1'b0));
    add_row(mk_event(OP_RECEIVING, 1'b1, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 1'b0, 0,
                     8'h0), 1'b1,
            mk_status(1'b1, OUT_PENDING, PH_RECEIVING, 1, CAUSE_UNKNOWN, 0, 0, 1'b1));
    add_row(mk_event(OP_PROGRESS, 1'b0, 0, 0, 0, 32'hFFFF_FFFF, 0, 1'b0, 0, 8'h0), 1'b1,
            mk_status(1'b1, OUT_PENDING, PH_RECEIVING, 1, CAUSE_UNKNOWN, 0, 32'hFFFF_FFFF,
                      1'b1));
    add_row(mk_event(OP_PROGRESS, 1'b0, 0, 0, 0, 32'h0, 0, 1'b0, 0, 8'h0), 1'b0, '0);
    add_row(mk_event(OP_VERIFYING, 1'b1, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 1'b0, 0,
                     8'h0), 1'b0, '0);
    add_row(mk_event(OP_FINALIZE_FAIL, 1'b0, 0, 0, 0, 0, 32'h8000_0000, 1'b0, 0, 8'h0),
            1'b0, '0);
    add_row(mk_event(OP_PROGRESS, 1'b0, 0, 0, 0, 32'h1, 0, 1'b0, 0, 8'h0), 1'b0, '0);
    add_row(mk_event(OP_VERIFYING, 1'b1, 32'h1, 32'h2, 32'h1, 0, 0, 1'b0, 0, 8'h0), 1'b0, '0);
    add_row(mk_event(OP_VERIFIED, 1'b0, 0, 0, 0, 0, 0, 1'b0, 0, 8'h0), 1'b0, '0);
    add_row(mk_event(OP_BOOTSEL_FAIL, 1'b0, 0, 0, 0, 0, 32'h7FFF_FFFF, 1'b0, 0, 8'h0),
            1'b0, '0);
    add_row(mk_event(OP_RECEIVING, 1'b1, a, b, 100, 0, 0, 1'b0, 0, 8'h0), 1'b0, '0);
    add_row(mk_event(OP_PROGRESS, 1'b0, 0, 0, 0, 101, 0, 1'b0, 0, 8'h0), 1'b0, '0);
    add_row(mk_event(OP_PROGRESS, 1'b0, 0, 0, 0, 100, 0, 1'b0, 0, 8'h0), 1'b0, '0);
    // pending but no running slot known
    add_row(mk_event(OP_BOOT_CHECK, 1'b0, 0, 0, 0, 0, 0, 1'b0, a, 8'h3), 1'b0, '0);
    add_row(mk_event(OP_BOOT_CHECK, 1'b0, 0, 0, 0, 0, 0, 1'b1, a, 8'h0), 1'b0, '0);
    add_row(mk_event(OP_BOOT_SELECTED, 1'b1, a, b, 100, 0, 0, 1'b0, 0, 8'h0), 1'b0, '0);
    add_row(mk_event(OP_BOOT_CHECK, 1'b0, 0, 0, 0, 0, 0, 1'b1, a, 8'hFF), 1'b0, '0);
    add_row(mk_event(OP_VERIFYING, 1'b1, a, b, 100, 0, 0, 1'b0, 0, 8'h0), 1'b0, '0);
    add_row(mk_event(OP_BOOT_SELECTED, 1'b1, a, b, 100, 0, 0, 1'b0, 0, 8'h0), 1'b0, '0);
    add_row(mk_event(OP_BOOT_CHECK, 1'b0, 0, 0, 0, 0, 0, 1'b1, b, 8'h5A), 1'b0, '0);
    add_row(mk_event(OP_VERIFYING, 1'b1, a, b, 100, 0, 0, 1'b0, 0, 8'h0), 1'b0, '0);
    add_row(mk_event(OP_BOOT_CHECK, 1'b0, 0, 0, 0, 0, 0, 1'b1, 32'h0820_0000, 8'h1),
            1'b0, '0);
    add_row(mk_event(OP_VERIFYING, 1'b1, a, b, 100, 0, 0, 1'b0, 0, 8'h0), 1'b0, '0);
    add_row(mk_event(OP_BOOT_CHECK, 1'b0, 0, 0, 0, 0, 0, 1'b1, a, 8'h2), 1'b0, '0);
  endfunction

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h0801_0000;
      3: return 32'h0810_0000;
      4: return 32'h0820_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_size();
    case ($urandom_range(15))
      0: return 32'hFFFF_FFFF;
      1: return 32'h1;
      2: return ($urandom | 32'h1);
      default: return $urandom_range(4096, 1);
    endcase
  endfunction

  function automatic uat_event_t noise_event();
    uat_event_t ev;
    ev = mk_event(3'($urandom_range(7)), 1'($urandom_range(1)), $urandom, $urandom,
                  ($urandom_range(3) == 0) ? 32'h0 : $urandom, $urandom, $urandom,
                  1'($urandom_range(1)), $urandom, 8'($urandom_range(255)));
    return ev;
  endfunction

  // start event of the current flow; other fields carry random junk
  function automatic uat_event_t flow_event(input logic [2:0] op);
    uat_event_t ev;
    ev = noise_event();
    ev.opcode        = op;
    ev.slots_present = 1'b1;
    ev.source_addr   = gen_src;
    ev.target_addr   = gen_tgt;
    ev.image_size    = gen_size;
    return ev;
  endfunction

  // one well-formed update flow with random content
  function automatic void plan_update();
    uat_event_t ev;
    int unsigned start_pick;
    int unsigned n_prog;
    int unsigned tail;
    if (gen_size == 32'h0 || $urandom_range(3) != 0) begin
      gen_src  = pick_addr();
      gen_tgt  = pick_addr();
      gen_size = pick_size();
    end
    start_pick = $urandom_range(19);
    if (start_pick < 14) begin
      script_q.push_back(flow_event(OP_RECEIVING));
      n_prog = $urandom_range(3);
      for (int unsigned i = 0; i < n_prog; i++) begin
        ev = noise_event();
        ev.opcode = OP_PROGRESS;
        case ($urandom_range(5))
          0: ev.received_size = gen_size;
          1: ev.received_size = (gen_size == 32'hFFFF_FFFF) ? gen_size : gen_size + 32'd1;
          2: ev.received_size = $urandom;
          default: ev.received_size = $urandom_range(gen_size, 0);
        endcase
        script_q.push_back(ev);
      end
      if ($urandom_range(3) != 0) begin
        ev = flow_event(OP_VERIFYING);
        if ($urandom_range(9) == 0) ev.image_size = gen_size ^ 32'h1;
        script_q.push_back(ev);
      end
    end else if (start_pick < 17) begin
      script_q.push_back(flow_event(OP_VERIFYING));
    end else begin
      script_q.push_back(flow_event(OP_BOOT_SELECTED));
    end
    tail = $urandom_range(19);
    if (tail < 3) begin
      ev = noise_event();
      ev.opcode = OP_FINALIZE_FAIL;
      script_q.push_back(ev);
    end else if (tail < 15) begin
      ev = noise_event();
      ev.opcode = OP_VERIFIED;
      script_q.push_back(ev);
      case ($urandom_range(4))
        0: begin
          ev = noise_event();
          ev.opcode = OP_BOOTSEL_FAIL;
          script_q.push_back(ev);
        end
        1, 2, 3: script_q.push_back(flow_event(OP_BOOT_SELECTED));
        default: begin
        end
      endcase
    end
    if ($urandom_range(19) < 17) begin
      ev = noise_event();
      ev.opcode          = OP_BOOT_CHECK;
      ev.running_present = ($urandom_range(9) != 0);
      case ($urandom_range(2))
        0: ev.running_addr = gen_tgt;
        1: ev.running_addr = gen_src;
        default: ev.running_addr = pick_addr();
      endcase
      script_q.push_back(ev);
    end
  endfunction

  task automatic send_item(input uat_event_t ev, input bit fixed_on,
                           input uat_result_t fixed);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      evt.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    evt.valid           <= 1'b1;
    evt.opcode          <= ev.opcode;
    evt.slots_present   <= ev.slots_present;
    evt.source_addr     <= ev.source_addr;
    evt.target_addr     <= ev.target_addr;
    evt.image_size      <= ev.image_size;
    evt.received_size   <= ev.received_size;
    evt.error_value     <= ev.error_value;
    evt.running_present <= ev.running_present;
    evt.running_addr    <= ev.running_addr;
    evt.reset_cause     <= ev.reset_cause;
    row_fixed_on        <= fixed_on;
    row_fixed           <= fixed;
    do @(posedge clk_i); while (!(evt.valid && evt.ready));
  endtask

  task automatic run_traffic(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (script_q.size() == 0) begin
        if ($urandom_range(9) < 8) plan_update();
        else script_q.push_back(noise_event());
      end
      send_item(script_q.pop_front(), 1'b0, '0);
    end
    evt.valid <= 1'b0;
  endtask

  // wait for every result, then let the pipeline run dry
  task automatic settle();
    @(posedge clk_i);
    evt.valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic config_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_STORAGE) store_open = data[0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    if (addr == ADDR_STORAGE) begin
      // read back
      psel    <= 1'b1;
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      if (prdata[0] !== data[0])
        flag_mismatch("storage_ready readback", prdata, 32'(data[0]));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    evt.valid           = 1'b0;
    evt.opcode          = OP_BOOT_CHECK;
    evt.slots_present   = 1'b0;
    evt.source_addr     = '0;
    evt.target_addr     = '0;
    evt.image_size      = '0;
    evt.received_size   = '0;
    evt.error_value     = '0;
    evt.running_present = 1'b0;
    evt.running_addr    = '0;
    evt.reset_cause     = '0;
    row_fixed_on        = 1'b0;
    row_fixed           = '0;
    gen_src             = '0;
    gen_tgt             = '0;
    gen_size            = '0;

    store_open      = 1'b1;
    trk             = '0;
    trk.outcome     = OUT_NONE;
    trk.phase       = PH_NONE;
    trk.reset_cause = CAUSE_UNKNOWN;
    trk.healthy     = 1'b1;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table on the reset configuration
    load_directed();
    foreach (dir_rows[i]) send_item(dir_rows[i].ev, dir_rows[i].fixed_on, dir_rows[i].fixed);
    evt.valid <= 1'b0;
    settle();

    config_write(ADDR_STORAGE, 32'h1);
    config_write(ADDR_SPARE, 32'h0);

    // back to back, receiver held off at first so the input stalls
    hold_len = 250;
    run_traffic(300);
    settle();

    idle_pct = 77;
    run_traffic(300);
    settle();

    // store closed: every item is rejected
    config_write(ADDR_STORAGE, 32'h0);
    idle_pct  = 0;
    stall_pct = 77;
    run_traffic(150);
    settle();

    config_write(ADDR_STORAGE, 32'hFFFF_FFFF);
    run_traffic(350);
    settle();

    idle_pct  = 38;
    stall_pct = 38;
    run_traffic(400);
    settle();

    if (status_due.size() != 0)
      flag_mismatch("missing results", 32'(status_due.size()), 32'h0);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
